@@ rtl/core/lrcc_pkg.sv @@
// shared types, codes and the crc32c byte update for the log record crc checker
package lrcc_pkg;

	localparam int unsigned HdrLen = 7;
	localparam int unsigned PosW = 17;
	localparam logic [15:0] TOMBSTONE_MARK = 16'hFFFF;
	localparam logic [31:0] CRC_POLY = 32'h82F63B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	// byte_kind codes
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_KEY = 2'd1;
	localparam logic [1:0] KIND_VALUE = 2'd2;

	// status codes
	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_CRC_MISMATCH = 2'd1;
	localparam logic [1:0] STATUS_TOMBSTONE = 2'd2;
	localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic source_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] byte_kind;
		logic record_done;
		logic [1:0] status;
		logic [7:0] key_length;
		logic [15:0] value_length;
	} out_item_t;

	// reflected crc32c, one byte, unrolled over its eight bits
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ rtl/core/log_record_crc_checker.sv @@
// log record crc checker: byte stream tagging, crc32c check and record status
//
// Takes one record byte per transaction and returns one tagged byte per
// transaction, so a byte can be accepted in every cycle unless the output
// is stalled; each result is held in a single output register and appears
// in the cycle after its byte is accepted. The header is a little-endian
// stored crc32c (4 bytes), a key length (1 byte) and a little-endian value
// length (2 bytes, all ones marks a tombstone with an empty value). The crc
// covers header bytes 4 to 6, the key and the value. record_done and status
// come with the record's last byte, or with any byte marked source_end
// before that (status truncated); the checker then starts on a new record.
// check_enable may only be written while no transaction is in flight.
module log_record_crc_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input lrcc_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output lrcc_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic cfg_wdata
);

	logic check_enable_q;
	logic [lrcc_pkg::PosW-1:0] pos_q;
	logic [31:0] crc_q;
	logic [31:0] stored_crc_q;
	logic [7:0] key_count_q;
	logic [15:0] raw_vlen_q;
	logic out_valid_q;
	lrcc_pkg::out_item_t out_data_q;

	logic in_acc;
	logic [7:0] b;
	logic [31:0] stored_crc_next;
	logic [7:0] key_next;
	logic [15:0] raw_vlen_next;
	logic [31:0] crc_next;
	logic tomb;
	logic [15:0] vlen;
	logic [lrcc_pkg::PosW-1:0] last_pos;
	logic at_last;
	logic done;
	logic [1:0] kind;
	logic [1:0] status;
	lrcc_pkg::out_item_t result;

	assign in_stall = out_valid_q && out_stall;
	assign in_acc = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign b = in_data.in_byte;

	always_comb begin
		stored_crc_next = stored_crc_q;
		if (pos_q < lrcc_pkg::PosW'(4)) begin
			unique case (pos_q[1:0])
				2'd0: stored_crc_next[7:0] = stored_crc_q[7:0] | b;
				2'd1: stored_crc_next[15:8] = stored_crc_q[15:8] | b;
				2'd2: stored_crc_next[23:16] = stored_crc_q[23:16] | b;
				default: stored_crc_next[31:24] = stored_crc_q[31:24] | b;
			endcase
		end
		key_next = (pos_q == lrcc_pkg::PosW'(4)) ? b : key_count_q;
		raw_vlen_next = raw_vlen_q;
		if (pos_q == lrcc_pkg::PosW'(5)) begin
			raw_vlen_next[7:0] = b;
		end
		if (pos_q == lrcc_pkg::PosW'(6)) begin
			raw_vlen_next[15:8] = b;
		end
		crc_next = (pos_q >= lrcc_pkg::PosW'(4)) ? lrcc_pkg::crc32c_byte(crc_q, b) : crc_q;
	end

	always_comb begin
		priority if (pos_q < lrcc_pkg::PosW'(lrcc_pkg::HdrLen)) begin
			kind = lrcc_pkg::KIND_HEADER;
		end else if (pos_q < lrcc_pkg::PosW'(lrcc_pkg::HdrLen) + {9'd0, key_next}) begin
			kind = lrcc_pkg::KIND_KEY;
		end else begin
			kind = lrcc_pkg::KIND_VALUE;
		end
		tomb = raw_vlen_next == lrcc_pkg::TOMBSTONE_MARK;
		vlen = (pos_q >= lrcc_pkg::PosW'(6) && !tomb) ? raw_vlen_next : 16'd0;
		// index of the record's final byte
		last_pos = lrcc_pkg::PosW'(lrcc_pkg::HdrLen - 1) + {9'd0, key_next} + {1'b0, vlen};
		at_last = (pos_q >= lrcc_pkg::PosW'(6)) && (pos_q == last_pos);
		done = at_last || in_data.source_end;
		priority if (at_last) begin
			if (check_enable_q && ((crc_next ^ lrcc_pkg::CRC_INIT) != stored_crc_next)) begin
				status = lrcc_pkg::STATUS_CRC_MISMATCH;
			end else if (tomb) begin
				status = lrcc_pkg::STATUS_TOMBSTONE;
			end else begin
				status = lrcc_pkg::STATUS_OK;
			end
		end else if (in_data.source_end) begin
			status = lrcc_pkg::STATUS_TRUNCATED;
		end else begin
			status = lrcc_pkg::STATUS_OK;
		end
		result.out_byte = b;
		result.byte_kind = kind;
		result.record_done = done;
		result.status = status;
		result.key_length = key_next;
		result.value_length = vlen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_enable_q <= 1'b1;
			pos_q <= '0;
			crc_q <= lrcc_pkg::CRC_INIT;
			stored_crc_q <= '0;
			key_count_q <= '0;
			raw_vlen_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				check_enable_q <= cfg_wdata;
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				if (done) begin
					pos_q <= '0;
					crc_q <= lrcc_pkg::CRC_INIT;
					stored_crc_q <= '0;
					key_count_q <= '0;
					raw_vlen_q <= '0;
				end else begin
					pos_q <= pos_q + lrcc_pkg::PosW'(1);
					crc_q <= crc_next;
					stored_crc_q <= stored_crc_next;
					key_count_q <= key_next;
					raw_vlen_q <= raw_vlen_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_data_q <= result;
		end
	end

`ifndef SYNTHESIS
	// a finished record leaves the checker at the start of a new one
	a_done_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && done |=> pos_q == '0 && crc_q == lrcc_pkg::CRC_INIT)
		else $error("record state not cleared after record_done");

	// an accepted transaction always lands in the output register
	a_acc_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q)
		else $error("accepted transaction not presented");

	// status is only nonzero alongside record_done
	a_status_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_data_q.record_done || out_data_q.status == lrcc_pkg::STATUS_OK)
		else $error("status set without record_done");

	// value length bytes are not captured before their header slots
	a_vlen_clear_early: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < lrcc_pkg::PosW'(5) |-> raw_vlen_q == '0 && key_count_q == 8'd0
			|| pos_q == lrcc_pkg::PosW'(5) && raw_vlen_q == '0)
		else $error("length fields captured early");
`endif

endmodule
